// ===== hw/rtl/tlca_pkg.sv =====
// Shared types and constants for the tree LCA binary lifting engine.
package tlca_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_QCHK,
    S_LIFT,
    S_CLIMB,
    S_PARENT,
    S_DEPTH,
    S_BRD,
    S_BCHASE,
    S_BWR,
    S_EMIT
  } state_t;

  // One entry of the ancestor memory.
  typedef struct packed {
    logic              present;
    logic [NODE_W-1:0] anc;
  } anc_entry_t;

  // One entry of the node memory: loaded mark and depth.
  typedef struct packed {
    logic               loaded;
    logic [DEPTH_W-1:0] depth;
  } node_entry_t;

endpackage

// ===== hw/rtl/tlca_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_addr,
  output logic [WIDTH-1:0]                           ra_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rb_addr,
  output logic [WIDTH-1:0]                           rb_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    ra_data <= mem_r[ra_addr];
    rb_data <= mem_r[rb_addr];
  end

endmodule

// ===== hw/rtl/tree_lca_binary_lifting_top.sv =====
// Top level of the tree lowest-common-ancestor engine (binary lifting).
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   command, node, other_node, node_depth, is_root
//   out_     output     out_valid/out_stall status, ancestor, distance
//
// Every input word yields exactly one result word. Words are handled one at a
// time: in a query the lift walks one level per cycle and the climb reads both
// chains at one level per cycle through the two read ports of the ancestor
// memory, and a build fills each table entry above level 0 in turn (read the
// entry one level down, chase it one level down again, write).
// After reset a clearing pass zeroes the node memory so that no node reads as
// loaded; in_stall is high during that pass.
// in_stall is high while a word is in flight; a finished result waits in the
// output register, and a new word is taken while it waits.
module tree_lca_binary_lifting_top #(
  parameter int NODES      = 1024,
  parameter int LOG_LEVELS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [9:0]  in_node,
  input  logic [9:0]  in_other_node,
  input  logic [9:0]  in_node_depth,
  input  logic        in_is_root,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [9:0]  out_ancestor,
  output logic [10:0] out_distance
);

  localparam int NW        = tlca_pkg::NODE_W;
  localparam int DW        = tlca_pkg::DEPTH_W;
  localparam int DSW       = tlca_pkg::DIST_W;
  // Node address width, level field width and level counter width.
  localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LVW       = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
  localparam int LVC_W     = $clog2(LOG_LEVELS + 1);
  // The ancestor memory is organized as LOG_LEVELS rows of 2^NODE_AW nodes,
  // so that an entry address is the level and the node side by side.
  localparam int ANC_DEPTH = LOG_LEVELS * (1 << NODE_AW);
  localparam int ANC_AW    = (ANC_DEPTH > 1) ? $clog2(ANC_DEPTH) : 1;
  localparam int AEW       = $bits(tlca_pkg::anc_entry_t);
  localparam int NEW       = $bits(tlca_pkg::node_entry_t);

  function automatic logic [ANC_AW-1:0] slot(input logic [NODE_AW-1:0] n,
                                             input logic [LVW-1:0] lvl);
    slot = ANC_AW'({lvl, n});
  endfunction

  tlca_pkg::state_t state_r, state_nxt;

  logic [NODE_AW-1:0]    clr_r, clr_nxt;
  logic                  built_r, built_nxt;
  logic [NODE_AW-1:0]    a_r, a_nxt;
  logic [NODE_AW-1:0]    b_r, b_nxt;
  logic [NODE_AW-1:0]    c_r, c_nxt;
  logic [LOG_LEVELS-1:0] lift_r, lift_nxt;
  logic [LVC_W-1:0]      lv_r, lv_nxt;
  logic                  pend_r, pend_nxt;
  logic [DSW-1:0]        dsum_r, dsum_nxt;
  logic [NODE_AW-1:0]    bi_r, bi_nxt;
  logic [LVW-1:0]        blv_r, blv_nxt;
  logic                  bok_r, bok_nxt;
  logic                  res_status_r, res_status_nxt;
  logic [NW-1:0]         res_anc_r, res_anc_nxt;
  logic [DSW-1:0]        res_dist_r, res_dist_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_status_r, out_status_nxt;
  logic [NW-1:0]         out_anc_r, out_anc_nxt;
  logic [DSW-1:0]        out_dist_r, out_dist_nxt;

  // Memory ports.
  logic                  n_we;
  logic [NODE_AW-1:0]    n_waddr, n_ra_addr, n_rb_addr;
  tlca_pkg::node_entry_t n_wdata, n_ra_data, n_rb_data;
  logic                  an_we;
  logic [ANC_AW-1:0]     an_waddr, an_ra_addr, an_rb_addr;
  tlca_pkg::anc_entry_t  an_wdata, an_ra_data, an_rb_data;

  // Helpers for the datapath.
  logic                  accept;
  logic                  node_ok, other_ok;
  logic [NODE_AW-1:0]    in_node_a, in_other_a;
  logic [NODE_AW-1:0]    ra_anc_a, rb_anc_a;
  logic [NODE_AW-1:0]    lift_b_cur;
  logic                  climb_take;
  logic [NODE_AW-1:0]    climb_a_cur, climb_b_cur;
  logic [LVC_W-1:0]      climb_lvm1;
  logic [LVW-1:0]        blv_m1;
  logic [DSW-1:0]        twice_dc;
  logic                  chase_ok;

  tlca_ram #(
    .WIDTH (NEW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk     (clk),
    .we      (n_we),
    .waddr   (n_waddr),
    .wdata   (n_wdata),
    .ra_addr (n_ra_addr),
    .ra_data (n_ra_data),
    .rb_addr (n_rb_addr),
    .rb_data (n_rb_data)
  );

  tlca_ram #(
    .WIDTH (AEW),
    .DEPTH (ANC_DEPTH)
  ) u_anc_ram (
    .clk     (clk),
    .we      (an_we),
    .waddr   (an_waddr),
    .wdata   (an_wdata),
    .ra_addr (an_ra_addr),
    .ra_data (an_ra_data),
    .rb_addr (an_rb_addr),
    .rb_data (an_rb_data)
  );

  assign in_stall  = (state_r != tlca_pkg::S_IDLE);
  assign accept    = in_valid && (state_r == tlca_pkg::S_IDLE);

  assign node_ok    = (32'(in_node) < 32'(NODES));
  assign other_ok   = (32'(in_other_node) < 32'(NODES));
  assign in_node_a  = NODE_AW'(in_node);
  assign in_other_a = NODE_AW'(in_other_node);
  assign ra_anc_a   = NODE_AW'(an_ra_data.anc);
  assign rb_anc_a   = NODE_AW'(an_rb_data.anc);

  // Lifting: the read issued last cycle moves b up when its level bit was set
  // and an ancestor exists there.
  assign lift_b_cur = (pend_r && an_ra_data.present) ? ra_anc_a : b_r;

  // Climbing: both chains move together only where both ancestors exist and
  // still differ.
  assign climb_take  = pend_r && an_ra_data.present && an_rb_data.present &&
                       (an_ra_data.anc != an_rb_data.anc);
  assign climb_a_cur = climb_take ? ra_anc_a : a_r;
  assign climb_b_cur = climb_take ? rb_anc_a : b_r;
  assign climb_lvm1  = lv_r - LVC_W'(1);

  assign blv_m1   = blv_r - LVW'(1);
  assign twice_dc = {n_ra_data.depth, 1'b0};
  assign chase_ok = an_ra_data.present && (32'(an_ra_data.anc) < 32'(NODES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlca_pkg::S_CLR;
      clr_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    c_r          <= c_nxt;
    lift_r       <= lift_nxt;
    lv_r         <= lv_nxt;
    pend_r       <= pend_nxt;
    dsum_r       <= dsum_nxt;
    bi_r         <= bi_nxt;
    blv_r        <= blv_nxt;
    bok_r        <= bok_nxt;
    res_status_r <= res_status_nxt;
    res_anc_r    <= res_anc_nxt;
    res_dist_r   <= res_dist_nxt;
    out_status_r <= out_status_nxt;
    out_anc_r    <= out_anc_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    built_nxt      = built_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    lift_nxt       = lift_r;
    lv_nxt         = lv_r;
    pend_nxt       = pend_r;
    dsum_nxt       = dsum_r;
    bi_nxt         = bi_r;
    blv_nxt        = blv_r;
    bok_nxt        = bok_r;
    res_status_nxt = res_status_r;
    res_anc_nxt    = res_anc_r;
    res_dist_nxt   = res_dist_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_anc_nxt    = out_anc_r;
    out_dist_nxt   = out_dist_r;

    n_we       = 1'b0;
    n_waddr    = in_node_a;
    n_wdata    = '0;
    n_ra_addr  = a_r;
    n_rb_addr  = b_r;
    an_we      = 1'b0;
    an_waddr   = slot(in_node_a, '0);
    an_wdata   = '0;
    an_ra_addr = slot(a_r, '0);
    an_rb_addr = slot(b_r, '0);

    case (state_r)
      tlca_pkg::S_CLR: begin
        n_we    = 1'b1;
        n_waddr = clr_r;
        n_wdata = '0;
        clr_nxt = clr_r + NODE_AW'(1);
        if (clr_r == NODE_AW'(NODES - 1)) begin
          state_nxt = tlca_pkg::S_IDLE;
        end
      end

      tlca_pkg::S_IDLE: begin
        if (accept) begin
          res_status_nxt = 1'b1;
          res_anc_nxt    = '0;
          res_dist_nxt   = '0;
          state_nxt      = tlca_pkg::S_EMIT;
          case (in_command)
            tlca_pkg::CMD_LOAD: begin
              if (node_ok) begin
                n_we                 = 1'b1;
                n_waddr              = in_node_a;
                n_wdata.loaded       = 1'b1;
                n_wdata.depth        = in_node_depth;
                an_we                = 1'b1;
                an_waddr             = slot(in_node_a, '0);
                // A parent outside the node range makes the node a root.
                an_wdata.present     = !in_is_root && other_ok;
                an_wdata.anc         = (!in_is_root && other_ok) ? in_other_node : '0;
                built_nxt            = 1'b0;
                res_status_nxt       = 1'b0;
              end
            end
            tlca_pkg::CMD_BUILD: begin
              if (LOG_LEVELS == 1) begin
                built_nxt      = 1'b1;
                res_status_nxt = 1'b0;
              end else begin
                bi_nxt    = '0;
                blv_nxt   = LVW'(1);
                state_nxt = tlca_pkg::S_BRD;
              end
            end
            tlca_pkg::CMD_QUERY: begin
              if (built_r && node_ok && other_ok) begin
                n_ra_addr = in_node_a;
                n_rb_addr = in_other_a;
                a_nxt     = in_node_a;
                b_nxt     = in_other_a;
                state_nxt = tlca_pkg::S_QCHK;
              end
            end
            default: begin
              res_status_nxt = 1'b1;
            end
          endcase
        end
      end

      tlca_pkg::S_QCHK: begin
        if (!n_ra_data.loaded || !n_rb_data.loaded) begin
          state_nxt = tlca_pkg::S_EMIT;
        end else begin
          dsum_nxt = {1'b0, n_ra_data.depth} + {1'b0, n_rb_data.depth};
          // b ends up as the deeper node.
          if (n_ra_data.depth > n_rb_data.depth) begin
            a_nxt    = b_r;
            b_nxt    = a_r;
            lift_nxt = LOG_LEVELS'(DW'(n_ra_data.depth - n_rb_data.depth));
          end else begin
            lift_nxt = LOG_LEVELS'(DW'(n_rb_data.depth - n_ra_data.depth));
          end
          lv_nxt    = '0;
          pend_nxt  = 1'b0;
          state_nxt = tlca_pkg::S_LIFT;
        end
      end

      tlca_pkg::S_LIFT: begin
        b_nxt = lift_b_cur;
        if (lv_r != LVC_W'(LOG_LEVELS)) begin
          an_ra_addr = slot(lift_b_cur, lv_r[LVW-1:0]);
          pend_nxt   = lift_r[0];
          lift_nxt   = lift_r >> 1;
          lv_nxt     = lv_r + LVC_W'(1);
        end else if (a_r == lift_b_cur) begin
          c_nxt     = a_r;
          n_ra_addr = a_r;
          state_nxt = tlca_pkg::S_DEPTH;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = tlca_pkg::S_CLIMB;
        end
      end

      tlca_pkg::S_CLIMB: begin
        a_nxt = climb_a_cur;
        b_nxt = climb_b_cur;
        if (lv_r != '0) begin
          an_ra_addr = slot(climb_a_cur, climb_lvm1[LVW-1:0]);
          an_rb_addr = slot(climb_b_cur, climb_lvm1[LVW-1:0]);
          pend_nxt   = 1'b1;
          lv_nxt     = climb_lvm1;
        end else begin
          an_ra_addr = slot(climb_a_cur, '0);
          state_nxt  = tlca_pkg::S_PARENT;
        end
      end

      tlca_pkg::S_PARENT: begin
        // The meeting node is the parent of a, or a itself at a root.
        c_nxt     = an_ra_data.present ? ra_anc_a : a_r;
        n_ra_addr = an_ra_data.present ? ra_anc_a : a_r;
        state_nxt = tlca_pkg::S_DEPTH;
      end

      tlca_pkg::S_DEPTH: begin
        res_status_nxt = 1'b0;
        res_anc_nxt    = NW'(c_r);
        res_dist_nxt   = (dsum_r >= twice_dc) ? (dsum_r - twice_dc) : '0;
        state_nxt      = tlca_pkg::S_EMIT;
      end

      tlca_pkg::S_BRD: begin
        an_ra_addr = slot(bi_r, blv_m1);
        state_nxt  = tlca_pkg::S_BCHASE;
      end

      tlca_pkg::S_BCHASE: begin
        bok_nxt    = chase_ok;
        an_rb_addr = slot(ra_anc_a, blv_m1);
        state_nxt  = tlca_pkg::S_BWR;
      end

      tlca_pkg::S_BWR: begin
        an_we            = 1'b1;
        an_waddr         = slot(bi_r, blv_r);
        an_wdata.present = bok_r && an_rb_data.present;
        an_wdata.anc     = (bok_r && an_rb_data.present) ? an_rb_data.anc : '0;
        state_nxt        = tlca_pkg::S_BRD;
        if (bi_r == NODE_AW'(NODES - 1)) begin
          bi_nxt = '0;
          if (blv_r == LVW'(LOG_LEVELS - 1)) begin
            built_nxt      = 1'b1;
            res_status_nxt = 1'b0;
            state_nxt      = tlca_pkg::S_EMIT;
          end else begin
            blv_nxt = blv_r + LVW'(1);
          end
        end else begin
          bi_nxt = bi_r + NODE_AW'(1);
        end
      end

      tlca_pkg::S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_anc_nxt    = res_anc_r;
          out_dist_nxt   = res_dist_r;
          state_nxt      = tlca_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tlca_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_ancestor = out_anc_r;
  assign out_distance = out_dist_r;

endmodule

// ===== tb/sv/tree_lca_binary_lifting_top_tb.sv =====
// Self-checking testbench for the tree lowest-common-ancestor engine.
module tree_lca_binary_lifting_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_W  = tlca_pkg::NODE_W;
  localparam int DEPTH_W = tlca_pkg::DEPTH_W;
  localparam int DIST_W  = tlca_pkg::DIST_W;
  localparam int CMD_W   = tlca_pkg::CMD_W;

  localparam logic [CMD_W-1:0] CMD_LOAD  = tlca_pkg::CMD_LOAD;
  localparam logic [CMD_W-1:0] CMD_BUILD = tlca_pkg::CMD_BUILD;
  localparam logic [CMD_W-1:0] CMD_QUERY = tlca_pkg::CMD_QUERY;

  // Size of the engine under test; the tree mirror below uses the same numbers.
  localparam int NODE_COUNT = 1024;
  localparam int LEVELS     = 10;

  // The fourth command code has no meaning; the engine must reject it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One expected result word.
  typedef struct packed {
    logic              status;
    logic [NODE_W-1:0] ancestor;
    logic [DIST_W-1:0] distance;
  } lca_answer_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command;
  logic [NODE_W-1:0]  in_node;
  logic [NODE_W-1:0]  in_other_node;
  logic [DEPTH_W-1:0] in_node_depth;
  logic               in_is_root;
  logic               out_valid;
  logic               out_stall;
  logic               out_status;
  logic [NODE_W-1:0]  out_ancestor;
  logic [DIST_W-1:0]  out_distance;

  tree_lca_binary_lifting_top #(
    .NODES      (NODE_COUNT),
    .LOG_LEVELS (LEVELS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_node       (in_node),
    .in_other_node (in_other_node),
    .in_node_depth (in_node_depth),
    .in_is_root    (in_is_root),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_ancestor  (out_ancestor),
    .out_distance  (out_distance)
  );

  // Mirror of the engine's tree state. Level 0 of the lifting table is the
  // parent link; level k is the ancestor 2^k steps up. A cleared valid bit
  // means the chain ends before that many steps.
  bit [NODE_W-1:0]  lift_anc   [0:NODE_COUNT-1][0:LEVELS-1];
  bit               lift_ok    [0:NODE_COUNT-1][0:LEVELS-1];
  bit [DEPTH_W-1:0] depth_of   [0:NODE_COUNT-1];
  bit               node_loaded[0:NODE_COUNT-1];
  bit               table_ready;

  // Answers still owed by the engine, oldest first.
  lca_answer_t lca_answers[$];

  // Stimulus bookkeeping: nodes loaded so far, node ids never handed out,
  // and the deepest node of the chain that the generator keeps growing.
  int    loaded_ids[$];
  int    free_ids[$];
  int    chain_tip = -1;
  int    words_sent = 0;
  int    answer_faults = 0;
  bit    idle_en = 1'b1;

  lca_answer_t seen_answer;

  // 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Fill the ancestor table level by level: the 2^k ancestor is the 2^(k-1)
  // ancestor of the 2^(k-1) ancestor. Missing links propagate upward.
  function automatic void build_lifting_levels();
    bit [NODE_W-1:0] mid;
    for (int lv = 1; lv < LEVELS; lv++) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        lift_ok[i][lv]  = 1'b0;
        lift_anc[i][lv] = '0;
        if (lift_ok[i][lv-1]) begin
          mid = lift_anc[i][lv-1];
          if (lift_ok[mid][lv-1]) begin
            lift_anc[i][lv] = lift_anc[mid][lv-1];
            lift_ok[i][lv]  = 1'b1;
          end
        end
      end
    end
  endfunction

  // Classic binary lifting: raise the deeper node by the depth gap, then raise
  // both while their ancestors differ. A missing link simply stops that step,
  // and two separate trees end on whatever the shallower side reached.
  function automatic bit [NODE_W-1:0] common_ancestor(bit [NODE_W-1:0] x,
                                                      bit [NODE_W-1:0] y);
    bit [NODE_W-1:0]  lo;
    bit [NODE_W-1:0]  hi;
    bit [DEPTH_W-1:0] gap;
    if (depth_of[x] > depth_of[y]) begin
      lo = y;
      hi = x;
    end else begin
      lo = x;
      hi = y;
    end
    // The gap is a 10-bit difference, so only the low LEVELS bits matter.
    gap = depth_of[hi] - depth_of[lo];
    for (int lv = 0; lv < LEVELS; lv++) begin
      if (gap[lv] && lift_ok[hi][lv]) hi = lift_anc[hi][lv];
    end
    if (lo == hi) return lo;
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (lift_ok[lo][lv] && lift_ok[hi][lv] &&
          lift_anc[lo][lv] != lift_anc[hi][lv]) begin
        lo = lift_anc[lo][lv];
        hi = lift_anc[hi][lv];
      end
    end
    if (lift_ok[lo][0]) return lift_anc[lo][0];
    return lo;
  endfunction

  // Apply one accepted word to the mirror and return the answer it owes.
  function automatic lca_answer_t predict_lca_answer(logic [CMD_W-1:0]   cmd,
                                                     logic [NODE_W-1:0]  node,
                                                     logic [NODE_W-1:0]  other,
                                                     logic [DEPTH_W-1:0] dep,
                                                     logic               root);
    lca_answer_t     ans;
    bit [NODE_W-1:0] meet;
    int              span;
    ans = '0;
    case (cmd)
      CMD_LOAD: begin
        if (!node_loaded[node]) loaded_ids = {loaded_ids, int'(node)};
        node_loaded[node] = 1'b1;
        depth_of[node]    = dep;
        lift_ok[node][0]  = !root;
        lift_anc[node][0] = root ? '0 : other;
        // Any load makes the table stale until the next build.
        table_ready = 1'b0;
      end
      CMD_BUILD: begin
        build_lifting_levels();
        table_ready = 1'b1;
      end
      CMD_QUERY: begin
        if (!table_ready || !node_loaded[node] || !node_loaded[other]) begin
          ans.status = 1'b1;
        end else begin
          meet = common_ancestor(node, other);
          span = int'(depth_of[node]) + int'(depth_of[other]) -
                 2 * int'(depth_of[meet]);
          // Hand-made depths may put the meeting node too deep; clamp at zero.
          if (span < 0) span = 0;
          ans.ancestor = meet;
          ans.distance = span[DIST_W-1:0];
        end
      end
      default: begin
        ans.status = 1'b1;
      end
    endcase
    return ans;
  endfunction

  // Hand one word to the engine. Inputs change only at the falling edge, so
  // the engine sees them settled at the next rising edge. The word is taken
  // at the first rising edge with in_stall low, and the answer it owes is
  // queued right there, in acceptance order.
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] node,
                           logic [NODE_W-1:0] other, logic [DEPTH_W-1:0] dep,
                           logic root);
    // An optional gap before the word; the decision ignores in_stall.
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_node       <= node;
    in_other_node <= other;
    in_node_depth <= dep;
    in_is_root    <= root;
    do @(posedge clk); while (in_stall);
    lca_answers = {lca_answers, predict_lca_answer(cmd, node, other, dep, root)};
    words_sent++;
    // Valid stays high here; the next word either replaces the payload or
    // opens a gap, so valid never drops and rises within one step.
    @(negedge clk);
  endtask

  // Node id that has not been loaded yet, or any node once none is left.
  function automatic int take_fresh_node();
    int idx;
    int n;
    while (free_ids.size() != 0) begin
      idx = $urandom_range(0, free_ids.size() - 1);
      n   = free_ids[idx];
      free_ids.delete(idx);
      if (!node_loaded[n]) return n;
    end
    return $urandom_range(0, NODE_COUNT - 1);
  endfunction

  function automatic int pick_loaded_node();
    if (loaded_ids.size() == 0) return $urandom_range(0, NODE_COUNT - 1);
    return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
  endfunction

  // Load one node. Parents are always nodes that are already loaded, so the
  // engine never follows a link into memory that was never written. With
  // follow_tip set the word always grows the long chain by one fresh node.
  task automatic load_random_node(bit follow_tip);
    int               r;
    int               node;
    int               parent;
    logic [DEPTH_W-1:0] dep;
    r = $urandom_range(0, 99);
    if (follow_tip || r < 75 || loaded_ids.size() == 0) node = take_fresh_node();
    else node = pick_loaded_node();
    if (loaded_ids.size() == 0 || (follow_tip ? chain_tip < 0 : r < 6)) begin
      // A new root; now and then with a bogus depth.
      dep = (r < 2) ? DEPTH_W'($urandom_range(0, 1023)) : '0;
      send_word(CMD_LOAD, NODE_W'(node), NODE_W'($urandom_range(0, 1023)), dep, 1'b1);
      if (chain_tip < 0) chain_tip = node;
    end else begin
      parent = ((follow_tip || r < 45) && chain_tip >= 0) ? chain_tip
                                                          : pick_loaded_node();
      dep = (depth_of[parent] == '1) ? depth_of[parent] : depth_of[parent] + 1'b1;
      if (!follow_tip && r >= 96) dep = DEPTH_W'($urandom_range(0, 1023));
      send_word(CMD_LOAD, NODE_W'(node), NODE_W'(parent), dep, 1'b0);
      if (parent == chain_tip) chain_tip = node;
    end
  endtask

  // Mostly pairs of loaded nodes; some with a node that may be missing, some
  // with both sides equal, and a few words with the meaningless command.
  task automatic query_random_pair();
    int r;
    int a;
    int b;
    r = $urandom_range(0, 99);
    a = pick_loaded_node();
    b = pick_loaded_node();
    if (r < 8) b = $urandom_range(0, NODE_COUNT - 1);
    else if (r < 12) b = a;
    send_word((r >= 97) ? CMD_UNUSED : CMD_QUERY, NODE_W'(a), NODE_W'(b),
              DEPTH_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
  endtask

  // One round: grow the forest, rebuild the table, then ask questions.
  // Stray queries and bad commands among the loads must be rejected.
  task automatic run_forest_phase(int loads, int queries);
    int r;
    repeat (loads) begin
      r = $urandom_range(0, 99);
      if (r < 4) query_random_pair();
      else if (r < 6) send_word(CMD_UNUSED, NODE_W'($urandom_range(0, 1023)),
                                NODE_W'($urandom_range(0, 1023)),
                                DEPTH_W'($urandom_range(0, 1023)),
                                1'($urandom_range(0, 1)));
      else load_random_node(1'b0);
    end
    send_word(CMD_BUILD, NODE_W'($urandom_range(0, 1023)),
              NODE_W'($urandom_range(0, 1023)),
              DEPTH_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    repeat (queries) query_random_pair();
  endtask

  // A query before any build, the unused command, and a build over an empty
  // forest followed by a query on nodes that were never loaded.
  task automatic test_unbuilt_and_unknown();
    send_word(CMD_QUERY, 10'd0, 10'd1023, 10'd0, 1'b0);
    send_word(CMD_UNUSED, 10'd1023, 10'd1023, 10'd1023, 1'b1);
    send_word(CMD_BUILD, 10'd0, 10'd0, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd0, 10'd0, 10'd1023, 1'b1);
  endtask

  // Two small trees, one on both ends of the node range, a query made stale
  // by a load, a self query, a cross-tree query and a query on a missing node.
  task automatic test_small_forest();
    send_word(CMD_LOAD, 10'd0, 10'd1023, 10'd0, 1'b1);
    send_word(CMD_LOAD, 10'd1023, 10'd0, 10'd1, 1'b0);
    send_word(CMD_QUERY, 10'd0, 10'd1023, 10'd0, 1'b0);
    send_word(CMD_LOAD, 10'd512, 10'd0, 10'd0, 1'b1);
    send_word(CMD_LOAD, 10'd513, 10'd512, 10'd1, 1'b0);
    send_word(CMD_BUILD, 10'd1023, 10'd1023, 10'd1023, 1'b1);
    send_word(CMD_QUERY, 10'd1023, 10'd0, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd1023, 10'd1023, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd1023, 10'd513, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd1023, 10'd5, 10'd0, 1'b0);
    send_word(CMD_UNUSED, 10'd0, 10'd0, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd513, 10'd512, 10'd0, 1'b0);
  endtask

  // Depths that disagree with the links: a node far deeper than its parent
  // (a gap that lifts past the root) and a node shallower than its parent,
  // whose distance comes out negative and must be clamped.
  task automatic test_depth_corners();
    send_word(CMD_LOAD, 10'd700, 10'd0, 10'd1023, 1'b0);
    send_word(CMD_LOAD, 10'd702, 10'd0, 10'd9, 1'b0);
    send_word(CMD_LOAD, 10'd703, 10'd702, 10'd0, 1'b0);
    send_word(CMD_BUILD, 10'd0, 10'd0, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd700, 10'd1023, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd703, 10'd702, 10'd0, 1'b0);
    send_word(CMD_QUERY, 10'd0, 10'd700, 10'd0, 1'b0);
  endtask

  // Random forests; each round picks whether both sides idle or not.
  task automatic test_random_forests(int rounds);
    repeat (rounds) begin
      idle_en = ($urandom_range(0, 4) != 0);
      run_forest_phase($urandom_range(20, 50), $urandom_range(60, 100));
    end
  endtask

  // One chain of more than 512 links so that every table level holds real
  // ancestors and depth gaps use the top lifting step.
  task automatic test_long_chain();
    idle_en = 1'b1;
    repeat (520) load_random_node(1'b1);
    send_word(CMD_BUILD, 10'd0, 10'd0, 10'd0, 1'b0);
    repeat (120) query_random_pair();
  endtask

  // Keep on with random rounds up to the item budget, then finish with a
  // round at full rate on both sides.
  task automatic test_full_rate_tail();
    while (words_sent < 1250) test_random_forests(1);
    idle_en = 1'b0;
    run_forest_phase(30, 100);
  endtask

  // Result side: stall in short random bursts while idling is enabled.
  initial begin : result_stall_gen
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 5);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Every result word taken from the engine is matched against the oldest
  // answer still owed, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (lca_answers.size() == 0) begin
        $error("result word with no answer owed: status %0d ancestor %0d distance %0d",
               out_status, out_ancestor, out_distance);
        answer_faults++;
      end else begin
        seen_answer = lca_answers.pop_front();
        if (out_status !== seen_answer.status) begin
          $error("status: expected %0d, got %0d", seen_answer.status, out_status);
          answer_faults++;
        end
        if (out_ancestor !== seen_answer.ancestor) begin
          $error("ancestor: expected %0d, got %0d", seen_answer.ancestor, out_ancestor);
          answer_faults++;
        end
        if (out_distance !== seen_answer.distance) begin
          $error("distance: expected %0d, got %0d", seen_answer.distance, out_distance);
          answer_faults++;
        end
      end
    end
  end

  // Main sequence: reset once, run the tests in turn, drain, report.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_LOAD;
    in_node       = '0;
    in_other_node = '0;
    in_node_depth = '0;
    in_is_root    = 1'b0;
    for (int i = 0; i < NODE_COUNT; i++) free_ids = {free_ids, i};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // The engine holds in_stall high through its clearing pass after reset;
    // the first word simply waits for it.
    test_unbuilt_and_unknown();
    test_small_forest();
    test_depth_corners();
    test_random_forests(2);
    test_long_chain();
    test_full_rate_tail();

    in_valid <= 1'b0;
    while (lca_answers.size() != 0) @(posedge clk);
    // Every word owes exactly one answer, so a short quiet spell is enough
    // to catch any extra result word.
    repeat (50) @(posedge clk);
    if (answer_faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: about ten builds plus the queries and the clearing pass stay far
  // below this.
  initial begin
    #(40ms);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tlca_pkg.sv
hw/rtl/tlca_ram.sv
hw/rtl/tree_lca_binary_lifting_top.sv
tb/sv/tree_lca_binary_lifting_top_tb.sv
